FILE: design/fuap_pkg.sv
// ----------------------------------------------------------------------------
// fuap_pkg
// Shared types and constants for the FU-A packetizer.
// ----------------------------------------------------------------------------
package fuap_pkg;

    localparam int LENGTH_BITS    = 20;
    localparam int SUM_BITS       = ((LENGTH_BITS > 17) ? LENGTH_BITS : 17) + 2;
    localparam int SIZE_BITS      = 17;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CFG_MAX_PAYLOAD     = 8'd0;
    localparam logic [7:0] CFG_HEADER_OVERHEAD = 8'd1;

    localparam logic [15:0] MAX_PAYLOAD_RESET     = 16'd1420;
    localparam logic [6:0]  HEADER_OVERHEAD_RESET = 7'd16;
    localparam logic [15:0] MIN_PAYLOAD           = 16'd3;
    localparam logic [15:0] FU_BYTES              = 16'd2;

    localparam logic [7:0] NRI_MASK   = 8'hE0;
    localparam logic [7:0] TYPE_MASK  = 8'h1F;
    localparam logic [7:0] FU_A_TYPE  = 8'd28;
    localparam logic [7:0] START_BIT  = 8'h80;
    localparam logic [7:0] END_BIT    = 8'h40;

    localparam logic [1:0] PHASE_IND  = 2'd0;
    localparam logic [1:0] PHASE_HDR  = 2'd1;
    localparam logic [1:0] PHASE_DATA = 2'd2;

    typedef struct packed {
        logic                 has_fu;
        logic [7:0]           ind;
        logic [7:0]           hdr;
        logic [7:0]           data;
        logic                 data_first;
        logic                 data_final;
        logic [SIZE_BITS-1:0] size;
        logic                 fend;
        logic [31:0]          stamp;
        logic [7:0]           kind;
        logic [7:0]           channel;
    } job_t;

endpackage

FILE: design/fuap_front.sv
// ----------------------------------------------------------------------------
// fuap_front
// Accepts NAL bytes, tracks unit/fragment state, builds a job per emitted byte.
// ----------------------------------------------------------------------------
module fuap_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [7:0]                       cfg_index,
    input  logic [15:0]                      cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       nal_byte,
    input  logic                             nal_start,
    input  logic [fuap_pkg::LENGTH_BITS-1:0] nal_length,
    input  logic [31:0]                      stamp,
    input  logic [7:0]                       frame_kind,
    input  logic [7:0]                       channel_id,
    input  logic                             q_full,
    output logic                             q_push,
    output fuap_pkg::job_t                   q_job
);

    localparam int LB = fuap_pkg::LENGTH_BITS;
    localparam int SB = fuap_pkg::SUM_BITS;

    logic [15:0]   max_payload_reg;
    logic [6:0]    header_overhead_reg;
    logic          fragmenting_reg, fragmenting_next;
    logic [LB-1:0] bytes_left_reg, bytes_left_next;
    logic [15:0]   fill_reg, fill_next;
    logic [7:0]    fu_ind_reg, fu_ind_next;
    logic [7:0]    fu_hdr_reg, fu_hdr_next;
    logic          first_frag_reg, first_frag_next;

    logic          accept;
    logic          emit;
    logic          fits;
    logic          eff_frag;
    logic [15:0]   maxe;
    logic [15:0]   chunk;
    logic [LB-1:0] len;
    logic [LB-1:0] eff_left;
    logic [15:0]   eff_fill;
    logic [SB-1:0] avail;
    logic [SB-1:0] pass_size;
    logic [SB-1:0] data_cnt;
    logic [SB-1:0] frag_size;
    logic          last;
    logic          frag_final;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            max_payload_reg     <= fuap_pkg::MAX_PAYLOAD_RESET;
            header_overhead_reg <= fuap_pkg::HEADER_OVERHEAD_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                fuap_pkg::CFG_MAX_PAYLOAD:     max_payload_reg     <= cfg_data;
                fuap_pkg::CFG_HEADER_OVERHEAD: header_overhead_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        maxe      = (max_payload_reg < fuap_pkg::MIN_PAYLOAD) ? fuap_pkg::MIN_PAYLOAD
                                                             : max_payload_reg;
        chunk     = maxe - fuap_pkg::FU_BYTES;
        len       = (nal_length == '0) ? LB'(1) : nal_length;
        fits      = 33'(len) <= 33'(maxe);
        eff_fill  = nal_start ? 16'd0 : fill_reg;
        eff_left  = nal_start ? len : bytes_left_reg;
        eff_frag  = nal_start ? 1'b0 : fragmenting_reg;
        emit      = nal_start ? fits : (bytes_left_reg != '0);
        avail     = SB'(eff_fill) + SB'(eff_left);
        pass_size = avail + SB'(header_overhead_reg);
        last      = avail <= SB'(chunk);
        data_cnt  = last ? avail : SB'(chunk);
        frag_size = data_cnt + SB'(fuap_pkg::FU_BYTES) + SB'(header_overhead_reg);
        frag_final = (SB'(eff_fill) + SB'(1)) >= data_cnt;
    end

    always_comb begin
        q_job.ind     = fu_ind_reg;
        q_job.hdr     = fu_hdr_reg | (first_frag_reg ? fuap_pkg::START_BIT : 8'd0)
                                   | (last ? fuap_pkg::END_BIT : 8'd0);
        q_job.data    = nal_byte;
        q_job.stamp   = stamp;
        q_job.kind    = frame_kind;
        q_job.channel = channel_id;
        if (!eff_frag)
        begin
            q_job.has_fu     = 1'b0;
            q_job.data_first = (eff_fill == 16'd0);
            q_job.data_final = (eff_left == LB'(1));
            q_job.size       = pass_size[fuap_pkg::SIZE_BITS-1:0];
            q_job.fend       = 1'b1;
        end
        else
        begin
            q_job.has_fu     = (eff_fill == 16'd0);
            q_job.data_first = 1'b0;
            q_job.data_final = frag_final;
            q_job.size       = frag_size[fuap_pkg::SIZE_BITS-1:0];
            q_job.fend       = last;
        end
    end

    assign q_push = accept && emit;

    always_comb begin
        fragmenting_next = fragmenting_reg;
        bytes_left_next  = bytes_left_reg;
        fill_next        = fill_reg;
        fu_ind_next      = fu_ind_reg;
        fu_hdr_next      = fu_hdr_reg;
        first_frag_next  = first_frag_reg;
        if (accept)
        begin
            if (nal_start)
            begin
                fill_next = 16'd0;
                if (fits)
                begin
                    fragmenting_next = 1'b0;
                    bytes_left_next  = len;
                end
                else
                begin
                    fragmenting_next = 1'b1;
                    bytes_left_next  = len - LB'(1);
                    fu_ind_next      = (nal_byte & fuap_pkg::NRI_MASK) | fuap_pkg::FU_A_TYPE;
                    fu_hdr_next      = nal_byte & fuap_pkg::TYPE_MASK;
                    first_frag_next  = 1'b1;
                end
            end
            if (emit)
            begin
                fill_next       = eff_fill + 16'd1;
                bytes_left_next = eff_left - LB'(1);
                if (!eff_frag)
                begin
                    if (eff_left == LB'(1))
                        fill_next = 16'd0;
                end
                else
                begin
                    if (frag_final)
                    begin
                        fill_next       = 16'd0;
                        first_frag_next = 1'b0;
                    end
                    if (eff_left == LB'(1))
                    begin
                        fragmenting_next = 1'b0;
                        fill_next        = 16'd0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            fragmenting_reg <= 1'b0;
            bytes_left_reg  <= '0;
            fill_reg        <= 16'd0;
            fu_ind_reg      <= 8'd0;
            fu_hdr_reg      <= 8'd0;
            first_frag_reg  <= 1'b1;
        end
        else
        begin
            fragmenting_reg <= fragmenting_next;
            bytes_left_reg  <= bytes_left_next;
            fill_reg        <= fill_next;
            fu_ind_reg      <= fu_ind_next;
            fu_hdr_reg      <= fu_hdr_next;
            first_frag_reg  <= first_frag_next;
        end
    end

endmodule

FILE: design/fuap_queue.sv
// ----------------------------------------------------------------------------
// fuap_queue
// Small job FIFO between front and back; push and pop in the same cycle.
// ----------------------------------------------------------------------------
module fuap_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  fuap_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output fuap_pkg::job_t head
);

    localparam int PB = fuap_pkg::QUEUE_PTR_BITS;
    localparam int CB = fuap_pkg::QUEUE_CNT_BITS;

    fuap_pkg::job_t slot_reg [fuap_pkg::QUEUE_DEPTH];
    logic [PB-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PB-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CB-1:0]  count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign full      = (count_reg == CB'(fuap_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PB'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PB'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CB'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CB'(1);
    end

    always_ff @(posedge clk) begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: design/fuap_back.sv
// ----------------------------------------------------------------------------
// fuap_back
// Expands queued jobs into payload bytes through a registered output stage.
// ----------------------------------------------------------------------------
module fuap_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_not_empty,
    input  fuap_pkg::job_t                 q_head,
    output logic                           q_pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     out_byte,
    output logic                           packet_first,
    output logic                           packet_final,
    output logic [fuap_pkg::SIZE_BITS-1:0] packet_bytes,
    output logic                           frame_end,
    output logic [31:0]                    out_stamp,
    output logic [7:0]                     out_kind,
    output logic [7:0]                     out_channel,
    output logic                           run_last
);

    logic       valid_reg, valid_next;
    logic [1:0] phase_reg, phase_next;
    logic       load;
    logic       job_done;
    logic [7:0] sel_byte;
    logic       sel_first;
    logic       sel_final;

    assign load = q_not_empty && (!valid_reg || out_ready);

    always_comb begin
        sel_byte  = q_head.data;
        sel_first = q_head.data_first;
        sel_final = q_head.data_final;
        job_done  = 1'b1;
        if (q_head.has_fu)
        begin
            case (phase_reg)
                fuap_pkg::PHASE_IND:
                begin
                    sel_byte  = q_head.ind;
                    sel_first = 1'b1;
                    sel_final = 1'b0;
                    job_done  = 1'b0;
                end
                fuap_pkg::PHASE_HDR:
                begin
                    sel_byte  = q_head.hdr;
                    sel_first = 1'b0;
                    sel_final = 1'b0;
                    job_done  = 1'b0;
                end
                default:
                begin
                    sel_first = 1'b0;
                end
            endcase
        end
    end

    assign q_pop = load && job_done;

    always_comb begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        if (load)
        begin
            valid_next = 1'b1;
            phase_next = job_done ? fuap_pkg::PHASE_IND : phase_reg + 2'd1;
        end
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= fuap_pkg::PHASE_IND;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk) begin
        if (load)
        begin
            out_byte     <= sel_byte;
            packet_first <= sel_first;
            packet_final <= sel_final;
            packet_bytes <= q_head.size;
            frame_end    <= q_head.fend;
            out_stamp    <= q_head.stamp;
            out_kind     <= q_head.kind;
            out_channel  <= q_head.channel;
            run_last     <= job_done;
        end
    end

    assign out_valid = valid_reg;

endmodule

FILE: design/h264_fua_packetizer.sv
// ----------------------------------------------------------------------------
// h264_fua_packetizer
// H.264 RTP packetizer with FU-A fragmentation, one NAL byte in per request.
//
// Input channel (in_valid/in_ready): one NAL unit byte with its tags; the
// unit length is sampled on the byte marked nal_start. Output channel
// (out_valid/out_ready): one payload byte per request with packet marks.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 max_payload,
// index 1 header_overhead; write only while the block is idle.
// A byte passes the job queue and the output register before its first
// result. Throughput: one result byte per cycle when not stalled. A byte
// gives one result, or three at a fragment start (FU indicator, FU header,
// data), which the back end emits in turn; the four-entry job queue absorbs
// that, and input accepts one byte per cycle while the queue has room. The
// header byte of a fragmented unit is consumed and gives no result.
// Reset clears unit state and the queue and restores register defaults
// (max_payload 1420, header_overhead 16). When the receiver stalls the
// output register holds, the queue fills, and in_ready drops.
// ----------------------------------------------------------------------------
module h264_fua_packetizer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [7:0]                       cfg_index,
    input  logic [15:0]                      cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       nal_byte,
    input  logic                             nal_start,
    input  logic [fuap_pkg::LENGTH_BITS-1:0] nal_length,
    input  logic [31:0]                      stamp,
    input  logic [7:0]                       frame_kind,
    input  logic [7:0]                       channel_id,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       out_byte,
    output logic                             packet_first,
    output logic                             packet_final,
    output logic [fuap_pkg::SIZE_BITS-1:0]   packet_bytes,
    output logic                             frame_end,
    output logic [31:0]                      out_stamp,
    output logic [7:0]                       out_kind,
    output logic [7:0]                       out_channel,
    output logic                             run_last
);

    fuap_pkg::job_t push_job;
    fuap_pkg::job_t head_job;
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_not_empty;

    fuap_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .nal_byte   (nal_byte),
        .nal_start  (nal_start),
        .nal_length (nal_length),
        .stamp      (stamp),
        .frame_kind (frame_kind),
        .channel_id (channel_id),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (push_job)
    );

    fuap_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (head_job)
    );

    fuap_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_head       (head_job),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .packet_first (packet_first),
        .packet_final (packet_final),
        .packet_bytes (packet_bytes),
        .frame_end    (frame_end),
        .out_stamp    (out_stamp),
        .out_kind     (out_kind),
        .out_channel  (out_channel),
        .run_last     (run_last)
    );

endmodule
